@@ rtl/core/itp_pkg.sv @@
// Shared types, constants and helper functions for the infix-to-postfix converter.
package itp_pkg;

    // Operator stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_MAX = SP_W'(STACK_DEPTH - 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // ASCII characters of interest
    localparam logic [7:0] CH_A     = 8'h61;  // 'a'
    localparam logic [7:0] CH_Z     = 8'h7A;  // 'z'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
    localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
    localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
    localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Stack entry codes
    localparam logic [2:0] CODE_OPEN  = 3'd0;
    localparam logic [2:0] CODE_PLUS  = 3'd1;
    localparam logic [2:0] CODE_MINUS = 3'd2;
    localparam logic [2:0] CODE_MUL   = 3'd3;
    localparam logic [2:0] CODE_DIV   = 3'd4;

    // Error codes carried on the terminator
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_CLOSE    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_OPEN     = 2'd3;

    typedef enum logic [2:0] {
        K_IGNORE,
        K_LETTER,
        K_OPEN,
        K_CLOSE,
        K_OPER
    } t_kind;

    // Classified request handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [2:0] code;
        logic [7:0] sym;
        logic       last;
    } t_cmd;

    // One result before the last-of-run flag is known
    typedef struct packed {
        logic [7:0] sym;
        logic       term;
        logic [1:0] err;
    } t_result;

    function automatic logic [1:0] rank_of(input logic [2:0] code);
        logic [1:0] r;
        case (code)
            CODE_PLUS, CODE_MINUS: r = 2'd1;
            CODE_MUL, CODE_DIV:    r = 2'd2;
            default:               r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_char(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            CODE_OPEN:  c = CH_OPEN;
            CODE_PLUS:  c = CH_PLUS;
            CODE_MINUS: c = CH_MINUS;
            CODE_MUL:   c = CH_MUL;
            CODE_DIV:   c = CH_DIV;
            default:    c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/itp_front.sv @@
// Front end: takes input requests and classifies each character into a command.
module itp_front
    import itp_pkg::*;
(
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_symbol,
    input  logic       i_end_of_expression,
    input  logic       i_queue_full,
    output logic       o_wr_en,
    output t_cmd       o_wr_cmd
);

    assign o_ready = !i_queue_full;
    assign o_wr_en = i_valid && !i_queue_full;

    always_comb begin
        o_wr_cmd.sym  = i_in_symbol;
        o_wr_cmd.last = i_end_of_expression;
        o_wr_cmd.code = CODE_OPEN;
        o_wr_cmd.kind = K_IGNORE;
        if (i_in_symbol >= CH_A && i_in_symbol <= CH_Z) begin
            o_wr_cmd.kind = K_LETTER;
        end else begin
            case (i_in_symbol)
                CH_OPEN: begin
                    o_wr_cmd.kind = K_OPEN;
                end
                CH_CLOSE: begin
                    o_wr_cmd.kind = K_CLOSE;
                end
                CH_PLUS: begin
                    o_wr_cmd.kind = K_OPER;
                    o_wr_cmd.code = CODE_PLUS;
                end
                CH_MINUS: begin
                    o_wr_cmd.kind = K_OPER;
                    o_wr_cmd.code = CODE_MINUS;
                end
                CH_MUL: begin
                    o_wr_cmd.kind = K_OPER;
                    o_wr_cmd.code = CODE_MUL;
                end
                CH_DIV: begin
                    o_wr_cmd.kind = K_OPER;
                    o_wr_cmd.code = CODE_DIV;
                end
                default: begin
                    o_wr_cmd.kind = K_IGNORE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/itp_queue.sv @@
// Short command queue decoupling the front end from the stack sequencer.
module itp_queue
    import itp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_en,
    input  t_cmd i_wr_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_rd_en
);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count;

    logic [QP_W-1:0] n_wr_ptr;
    logic [QP_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == QC_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_rd_en) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_wr_en, i_rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/core/itp_back.sv @@
// Back end: operator stack sequencer with a hold stage and output register.
module itp_back
    import itp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_symbol,
    output logic       o_is_terminator,
    output logic       o_last_of_run,
    output logic [1:0] o_error_code
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_FIN
    } t_state;

    logic [2:0]      r_stack [STACK_DEPTH];
    t_state          r_state;
    t_state          n_state;
    logic [SP_W-1:0] r_sp;
    logic [SP_W-1:0] n_sp;
    logic [2:0]      r_top;
    logic [1:0]      r_err;
    logic            r_hold_valid;
    t_result         r_hold;
    logic            r_out_valid;
    t_result         r_out;
    logic            r_out_last;

    logic            top_live;
    logic            top_is_op;
    logic            out_free;
    logic            emit_en;
    t_result         emit_res;
    logic            fin_en;
    logic            pop_en;
    logic            push_en;
    logic [2:0]      push_code;
    logic            push_ok;
    logic            clear_en;
    logic            note_en;
    logic [1:0]      note_code;
    logic            cmd_done;
    logic            out_load;
    t_result         out_data;
    logic            out_last;
    logic            go;

    assign top_live  = (r_sp != '0);
    assign top_is_op = top_live && (r_top != CODE_OPEN);
    assign out_free  = !r_out_valid || i_ready;
    assign push_ok   = (r_sp != SP_MAX);

    // Work out what the current cycle wants to do
    always_comb begin
        n_state   = r_state;
        emit_en   = 1'b0;
        emit_res  = '{sym: code_char(r_top), term: 1'b0, err: ERR_NONE};
        fin_en    = 1'b0;
        pop_en    = 1'b0;
        push_en   = 1'b0;
        push_code = CODE_OPEN;
        clear_en  = 1'b0;
        note_en   = 1'b0;
        note_code = ERR_NONE;
        cmd_done  = 1'b0;
        case (r_state)
            ST_RUN: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        K_LETTER: begin
                            emit_en      = 1'b1;
                            emit_res.sym = i_cmd.sym;
                            cmd_done     = 1'b1;
                        end
                        K_OPEN: begin
                            push_en   = 1'b1;
                            push_code = CODE_OPEN;
                            cmd_done  = 1'b1;
                        end
                        K_OPER: begin
                            if (top_live && rank_of(r_top) >= rank_of(i_cmd.code)) begin
                                emit_en = 1'b1;
                                pop_en  = 1'b1;
                            end else begin
                                push_en   = 1'b1;
                                push_code = i_cmd.code;
                                cmd_done  = 1'b1;
                            end
                        end
                        K_CLOSE: begin
                            if (top_is_op) begin
                                emit_en = 1'b1;
                                pop_en  = 1'b1;
                            end else begin
                                // matching open dropped; sentinel reached means unmatched
                                if (top_live) begin
                                    pop_en = 1'b1;
                                end else begin
                                    note_en   = 1'b1;
                                    note_code = ERR_CLOSE;
                                end
                                cmd_done = 1'b1;
                            end
                        end
                        default: begin
                            cmd_done = 1'b1;
                        end
                    endcase
                    if (cmd_done) begin
                        if (i_cmd.last) begin
                            n_state = ST_FLUSH;
                        end else begin
                            fin_en = 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (top_is_op) begin
                    emit_en = 1'b1;
                    pop_en  = 1'b1;
                end else begin
                    emit_en       = 1'b1;
                    emit_res.sym  = CH_NUL;
                    emit_res.term = 1'b1;
                    if (r_err != ERR_NONE) begin
                        emit_res.err = r_err;
                    end else if (top_live) begin
                        emit_res.err = ERR_OPEN;
                    end else begin
                        emit_res.err = ERR_NONE;
                    end
                    clear_en = 1'b1;
                    n_state  = ST_FIN;
                end
            end
            ST_FIN: begin
                fin_en  = 1'b1;
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // Routing into the output register; emit+finish together only with an empty hold
    always_comb begin
        out_load = 1'b0;
        out_data = r_hold;
        out_last = 1'b0;
        if (emit_en && fin_en) begin
            out_load = 1'b1;
            out_data = emit_res;
            out_last = 1'b1;
        end else if (emit_en) begin
            out_load = r_hold_valid;
        end else if (fin_en) begin
            out_load = r_hold_valid;
            out_last = 1'b1;
        end
    end

    assign go        = !out_load || out_free;
    assign o_cmd_pop = go && fin_en;

    always_comb begin
        n_sp = r_sp;
        if (clear_en) begin
            n_sp = '0;
        end else if (pop_en) begin
            n_sp = r_sp - 1'b1;
        end else if (push_en && push_ok) begin
            n_sp = r_sp + 1'b1;
        end
    end

    // Stack memory; r_top tracks the entry at the stack pointer
    always_ff @(posedge i_clk) begin
        if (go && push_en && push_ok) begin
            r_stack[n_sp] <= push_code;
            r_top         <= push_code;
        end else if (go) begin
            r_top <= r_stack[n_sp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_RUN;
            r_sp         <= '0;
            r_err        <= ERR_NONE;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (go) begin
                r_state <= n_state;
                r_sp    <= n_sp;
                if (clear_en) begin
                    r_err <= ERR_NONE;
                end else if (r_err == ERR_NONE) begin
                    if (note_en) begin
                        r_err <= note_code;
                    end else if (push_en && !push_ok) begin
                        r_err <= ERR_OVERFLOW;
                    end
                end
                if (emit_en && !fin_en) begin
                    r_hold_valid <= 1'b1;
                end else if (fin_en) begin
                    r_hold_valid <= 1'b0;
                end
            end
            if (go && out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit_en && !fin_en) begin
            r_hold <= emit_res;
        end
        if (go && out_load) begin
            r_out      <= out_data;
            r_out_last <= out_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_symbol    = r_out.sym;
    assign o_is_terminator = r_out.term;
    assign o_last_of_run   = r_out_last;
    assign o_error_code    = r_out.err;

`ifndef SYNTHESIS
    a_fin_holds_term : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FIN |-> r_hold_valid && r_hold.term)
        else $error("terminator not held on entry to finish state");

    a_fin_stack_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FIN |-> r_sp == '0 && r_err == ERR_NONE)
        else $error("stack or error not cleared after terminator");

    a_pair_needs_empty_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_en && fin_en |-> !r_hold_valid)
        else $error("direct emit while a result is held");

    a_pop_has_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> i_cmd_valid || r_state == ST_FIN)
        else $error("command popped from empty queue");

    a_no_pop_at_sentinel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_en |-> r_sp != '0)
        else $error("pop below sentinel");
`endif

endmodule

@@ rtl/core/infix_to_postfix_converter.sv @@
// Top level of the shunting-yard infix-to-postfix converter.
// A letter request is written into the queue, then the sequencer loads it into the
// output register; each popped operator takes a sequencer step of its own.
// Throughput: one request per cycle when nothing is popped and the consumer is ready;
// else one stack operation per sequencer cycle; expression end adds flush and finish.
// Reset: synchronous, active low; clears queue, stack pointer, sticky error and valids.
module infix_to_postfix_converter
    import itp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_symbol,
    input  logic       i_end_of_expression,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_symbol,
    output logic       o_is_terminator,
    output logic       o_last_of_run,
    output logic [1:0] o_error_code
);

    // Front -> queue
    logic q_wr_en;
    t_cmd q_wr_cmd;
    logic q_full;

    // Queue -> back
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // Front end classifies each character request as it is accepted.
    itp_front u_front (
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_in_symbol         (i_in_symbol),
        .i_end_of_expression (i_end_of_expression),
        .i_queue_full        (q_full),
        .o_wr_en             (q_wr_en),
        .o_wr_cmd            (q_wr_cmd)
    );

    // Short queue lets the front keep taking requests while the back pops operators.
    itp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (q_wr_en),
        .i_wr_cmd (q_wr_cmd),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_cmd    (q_cmd),
        .i_rd_en  (q_pop)
    );

    // Back end runs the stack; a hold stage marks the last result of each request,
    // and the output register decouples it from the consumer.
    itp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_cmd),
        .o_cmd_pop       (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_symbol    (o_out_symbol),
        .o_is_terminator (o_is_terminator),
        .o_last_of_run   (o_last_of_run),
        .o_error_code    (o_error_code)
    );

endmodule

@@ verif/infix_to_postfix_converter_tb.sv @@
// Self-checking testbench for the shunting-yard infix-to-postfix converter.
module infix_to_postfix_converter_tb;
    import itp_pkg::*;

    // Space is the ignored character that the generator likes to sprinkle
    localparam logic [7:0] CH_SPACE   = 8'h20;
    // No handshake on either side for this long means the block has hung
    localparam int         STALL_LIMIT = 4000;
    // Settling time after the last result, well past the pipeline depth
    localparam int         TAIL_CYCLES = 20;

    // One expected postfix result
    typedef struct packed {
        logic [7:0] sym;
        logic       term;
        logic       last;
        logic [1:0] err;
    } postfix_out_t;

    logic       i_clk               = 1'b0;
    logic       i_rst_n             = 1'b0;
    logic       i_valid             = 1'b0;
    logic [7:0] i_in_symbol         = 8'h00;
    logic       i_end_of_expression = 1'b0;
    logic       i_ready             = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_symbol;
    logic       o_is_terminator;
    logic       o_last_of_run;
    logic [1:0] o_error_code;

    // Predictor state: operator stack with its sentinel at entry 0
    logic [2:0]   op_stack [STACK_DEPTH];
    int           op_top       = 0;
    logic [1:0]   first_error  = ERR_NONE;

    postfix_out_t pending_postfix[$];    // expected results, oldest first
    logic [7:0]   expr_chars[$];         // expression under construction
    int           useful_requests = 0;   // requests that the block does not ignore
    int           mismatches      = 0;
    int           stall_cycles    = 0;
    bit           steady          = 1'b0; // no idling on either side while set

    infix_to_postfix_converter dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_in_symbol         (i_in_symbol),
        .i_end_of_expression (i_end_of_expression),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_out_symbol        (o_out_symbol),
        .o_is_terminator     (o_is_terminator),
        .o_last_of_run       (o_last_of_run),
        .o_error_code        (o_error_code)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // '(' ranks lowest so it stops every operator pop
    function automatic int precedence(input logic [2:0] code);
        case (code)
            CODE_PLUS, CODE_MINUS: return 1;
            CODE_MUL, CODE_DIV:    return 2;
            default:               return 0;
        endcase
    endfunction

    // Only the first error of an expression survives to the terminator
    function automatic void note_error(input logic [1:0] err);
        if (first_error == ERR_NONE) begin
            first_error = err;
        end
    endfunction

    function automatic void push_op(input logic [2:0] code);
        if (op_top + 1 >= STACK_DEPTH) begin
            note_error(ERR_OVERFLOW);
        end else begin
            op_top++;
            op_stack[op_top] = code;
        end
    endfunction

    // Pop the top operator and expect its character on the output
    function automatic void emit_top();
        logic [7:0] c;
        case (op_stack[op_top])
            CODE_PLUS:  c = CH_PLUS;
            CODE_MINUS: c = CH_MINUS;
            CODE_MUL:   c = CH_MUL;
            CODE_DIV:   c = CH_DIV;
            default:    c = CH_OPEN;
        endcase
        pending_postfix.push_back('{c, 1'b0, 1'b0, ERR_NONE});
        op_top--;
    endfunction

    // Everything above the nearest '(' comes out; the '(' itself stays
    function automatic void pop_to_open();
        while (op_top > 0 && op_stack[op_top] != CODE_OPEN) begin
            emit_top();
        end
    endfunction

    // Work out the results that one accepted request causes
    function automatic void convert_symbol(input logic [7:0] sym, input logic eoe);
        int         run_start;
        logic [2:0] code;
        bit         is_op;
        run_start = pending_postfix.size();
        is_op     = 1'b1;
        case (sym)
            CH_PLUS:  code = CODE_PLUS;
            CH_MINUS: code = CODE_MINUS;
            CH_MUL:   code = CODE_MUL;
            CH_DIV:   code = CODE_DIV;
            default: begin
                code  = CODE_OPEN;
                is_op = 1'b0;
            end
        endcase

        if (sym >= CH_A && sym <= CH_Z) begin
            pending_postfix.push_back('{sym, 1'b0, 1'b0, ERR_NONE});
        end else if (sym == CH_OPEN) begin
            push_op(CODE_OPEN);
        end else if (is_op) begin
            // equal rank pops too: left associative
            while (op_top > 0 && precedence(op_stack[op_top]) >= precedence(code)) begin
                emit_top();
            end
            push_op(code);
        end else if (sym == CH_CLOSE) begin
            pop_to_open();
            if (op_top == 0) begin
                note_error(ERR_CLOSE);   // ran into the sentinel
            end else begin
                op_top--;                // drop the matching '('
            end
        end

        if (is_op || sym == CH_OPEN || sym == CH_CLOSE || (sym >= CH_A && sym <= CH_Z)
            || eoe) begin
            useful_requests++;
        end

        if (eoe) begin
            pop_to_open();
            if (op_top != 0) begin
                note_error(ERR_OPEN);    // an open paren was left standing
            end
            pending_postfix.push_back('{CH_NUL, 1'b1, 1'b0, first_error});
            op_top      = 0;
            first_error = ERR_NONE;
        end

        if (pending_postfix.size() > run_start) begin
            pending_postfix[pending_postfix.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Entered and left at a falling edge; predicts once the request is taken
    task automatic send_request(input logic [7:0] sym, input logic eoe);
        while (!steady && $urandom_range(0, 99) < 36) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid             <= 1'b1;
        i_in_symbol         <= sym;
        i_end_of_expression <= eoe;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        convert_symbol(sym, eoe);
        @(negedge i_clk);
    endtask

    // Hold the sender back until the block has caught up completely
    task automatic drain_results();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending_postfix.size() != 0);
    endtask

    task automatic send_expression();
        int i;
        for (i = 0; i < expr_chars.size(); i++) begin
            send_request(expr_chars[i], i == expr_chars.size() - 1);
        end
    endtask

    // Random well-formed infix text, optionally broken in one place
    function automatic void build_expression(input bit corrupt);
        logic [7:0] ops[4];
        int         opens;
        int         terms;
        bit         need_operand;
        int         idx;
        ops          = '{CH_PLUS, CH_MINUS, CH_MUL, CH_DIV};
        opens        = 0;
        terms        = $urandom_range(1, 6);
        need_operand = 1'b1;
        expr_chars.delete();
        while (terms > 0) begin
            if (need_operand) begin
                if (opens < 5 && $urandom_range(0, 3) == 0) begin
                    expr_chars.push_back(CH_OPEN);
                    opens++;
                end else begin
                    expr_chars.push_back(CH_A + 8'($urandom_range(0, 25)));
                    need_operand = 1'b0;
                    terms--;
                end
            end else if (opens > 0 && $urandom_range(0, 2) == 0) begin
                expr_chars.push_back(CH_CLOSE);
                opens--;
            end else begin
                expr_chars.push_back(ops[$urandom_range(0, 3)]);
                need_operand = 1'b1;
            end
        end
        repeat (opens) expr_chars.push_back(CH_CLOSE);

        if ($urandom_range(0, 4) == 0) begin
            expr_chars.insert($urandom_range(0, expr_chars.size() - 1), CH_SPACE);
        end
        if (corrupt) begin
            idx = $urandom_range(0, expr_chars.size() - 1);
            case ($urandom_range(0, 3))
                0: expr_chars.insert(idx, CH_OPEN);
                1: expr_chars.insert(idx, CH_CLOSE);
                2: expr_chars.insert(idx, 8'($urandom_range(0, 255)));
                default: begin
                    if (expr_chars.size() > 1) expr_chars.delete(idx);
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        i_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end

    // Each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        postfix_out_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_postfix.size() == 0) begin
                $error("unexpected result: out_symbol %0h", o_out_symbol);
                mismatches++;
            end else begin
                want = pending_postfix.pop_front();
                if (o_out_symbol !== want.sym) begin
                    $error("out_symbol: expected %0h, got %0h", want.sym, o_out_symbol);
                    mismatches++;
                end
                if (o_is_terminator !== want.term) begin
                    $error("is_terminator: expected %0b, got %0b", want.term, o_is_terminator);
                    mismatches++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, o_last_of_run);
                    mismatches++;
                end
                if (o_error_code !== want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, o_error_code);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any handshake on either side counts as progress
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Precedence, associativity, parens, ignored characters, close and open errors
    task automatic test_directed_cases();
        send_request(CH_A, 1'b0);
        send_request(CH_PLUS, 1'b0);
        send_request("b", 1'b0);
        send_request(CH_MUL, 1'b0);
        send_request("c", 1'b0);
        send_request(CH_MINUS, 1'b0);        // pops '*' then '+'
        send_request(CH_Z, 1'b0);
        send_request(CH_DIV, 1'b0);
        send_request(CH_OPEN, 1'b0);
        send_request("y", 1'b0);
        send_request(CH_CLOSE, 1'b0);
        send_request(8'h00, 1'b0);           // ignored, all bits low
        send_request(8'hFF, 1'b1);           // ignored char still ends the expression
        send_request(CH_CLOSE, 1'b0);        // unmatched close
        send_request(CH_OPEN, 1'b0);
        send_request(CH_A - 8'd1, 1'b0);     // just below the letters
        send_request(CH_Z + 8'd1, 1'b0);     // just above the letters
        send_request("q", 1'b1);             // open left too, close error kept
        send_request(CH_OPEN, 1'b0);
        send_request(CH_OPEN, 1'b1);         // unmatched open
        send_request(CH_CLOSE, 1'b1);        // close error on the last char
        send_request(CH_MINUS, 1'b0);
        send_request(CH_MINUS, 1'b0);        // equal rank pops the first
        send_request(CH_A, 1'b1);
    endtask

    // A long run with both sides always willing
    task automatic test_back_to_back();
        int target;
        target = useful_requests + 25;
        steady = 1'b1;
        while (useful_requests < target) begin
            build_expression($urandom_range(0, 4) == 0);
            send_expression();
        end
        steady = 1'b0;
    endtask

    // Main bulk: mostly good expressions, some broken, with full drains
    task automatic test_random_expressions();
        int target;
        int n;
        target = useful_requests + 60;
        n      = 0;
        while (useful_requests < target) begin
            build_expression($urandom_range(0, 3) == 0);
            send_expression();
            n++;
            if (n % 5 == 0) drain_results();
        end
    endtask

    // Nesting past the stack depth forces overflow; closes may run short
    task automatic test_deep_nesting();
        int depth;
        repeat (2) begin
            depth = $urandom_range(32, 36);
            expr_chars.delete();
            repeat (depth) begin
                expr_chars.push_back(CH_OPEN);
                if ($urandom_range(0, 3) == 0) begin
                    expr_chars.push_back(CH_A + 8'($urandom_range(0, 25)));
                    expr_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MUL);
                end
            end
            expr_chars.push_back(CH_A + 8'($urandom_range(0, 25)));
            repeat ($urandom_range(0, depth + 2)) expr_chars.push_back(CH_CLOSE);
            send_expression();
        end
    endtask

    // Arbitrary bytes with random expression ends
    task automatic test_noise();
        repeat (20) begin
            send_request(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_back_to_back();
        test_random_expressions();
        test_deep_nesting();
        test_noise();

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
